/* design/lebm_pkg.sv */
`default_nettype none

package lebm_pkg;

    // Default memory size in bytes
    localparam int unsigned MemBytesDef = 65536;

    // Banks across one row, one byte each
    localparam int unsigned NumBanks = 8;

    // Operation codes
    localparam logic OpLoad  = 1'b0;
    localparam logic OpStore = 1'b1;

    // Fault codes
    localparam logic [1:0] FaultNone  = 2'd0;
    localparam logic [1:0] FaultLoad  = 2'd1;
    localparam logic [1:0] FaultStore = 2'd2;

    // Supported access sizes in bits
    localparam logic [7:0] Size8  = 8'd8;
    localparam logic [7:0] Size16 = 8'd16;
    localparam logic [7:0] Size32 = 8'd32;
    localparam logic [7:0] Size64 = 8'd64;

    // Incoming request
    typedef struct packed {
        logic        opcode;
        logic [63:0] address;
        logic [7:0]  size_bits;
        logic [63:0] store_data;
    } t_req;

    // Delivered result
    typedef struct packed {
        logic [63:0] read_data;
        logic [1:0]  fault;
    } t_rsp;

    // Classified command passed from front to back
    typedef struct packed {
        logic        is_store;
        logic [1:0]  fault;
        logic [3:0]  nbytes;
        logic [63:0] addr;
        logic [63:0] data;
    } t_cmd;

    // Back-end sequencer states
    typedef enum logic {
        BkClear,
        BkRun
    } t_back_state;

endpackage

`default_nettype wire

/* design/lebm_ram.sv */
`default_nettype none

module lebm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8192
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write on enable, register the read every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

/* design/lebm_front.sv */
`default_nettype none

module lebm_front
    import lebm_pkg::*;
#(
    parameter int unsigned MEM_BYTES = MemBytesDef
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_req i_req,
    output logic      o_full,
    input  wire logic i_clearing,
    output logic      o_cmd_valid,
    output t_cmd      o_cmd,
    input  wire logic i_cmd_pop
);

    logic [3:0]  w_nbytes;
    logic        w_size_ok;
    logic [64:0] w_end;
    logic        w_oob;
    t_cmd        w_cmd;
    logic        w_push;

    t_cmd        r_q [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;

    // Decode size into a byte count
    always_comb begin
        w_nbytes  = 4'd0;
        w_size_ok = 1'b1;
        case (i_req.size_bits)
            Size8:   w_nbytes = 4'd1;
            Size16:  w_nbytes = 4'd2;
            Size32:  w_nbytes = 4'd4;
            Size64:  w_nbytes = 4'd8;
            default: w_size_ok = 1'b0;
        endcase
    end

    // Check bounds without address wrap
    assign w_end = {1'b0, i_req.address} + {61'd0, w_nbytes};
    assign w_oob = w_end > 65'(MEM_BYTES);

    // Build the classified request
    always_comb begin
        w_cmd          = '0;
        w_cmd.is_store = (i_req.opcode == OpStore);
        w_cmd.nbytes   = w_nbytes;
        w_cmd.addr     = i_req.address;
        w_cmd.data     = i_req.store_data;
        if (!w_size_ok || w_oob) begin
            w_cmd.fault = (i_req.opcode == OpStore) ? FaultStore : FaultLoad;
        end else begin
            w_cmd.fault = FaultNone;
        end
    end

    assign o_full = (r_cnt == 2'd2) || i_clearing;
    assign w_push = i_push && !o_full;

    // Hold classified requests in a two-entry queue
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !i_cmd_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && i_cmd_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (i_cmd_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

endmodule

`default_nettype wire

/* design/lebm_back.sv */
`default_nettype none

module lebm_back
    import lebm_pkg::*;
#(
    parameter int unsigned MEM_BYTES = MemBytesDef
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    output logic      o_clearing,
    output logic      o_empty,
    input  wire logic i_pop,
    output t_rsp      o_rsp
);

    localparam int unsigned Rows    = (MEM_BYTES + NumBanks - 1) / NumBanks;
    localparam int unsigned RowW    = (Rows > 1) ? $clog2(Rows) : 1;
    localparam int unsigned OqDepth = 4;
    localparam int unsigned OqPtrW  = $clog2(OqDepth);

    t_back_state r_state;
    t_back_state n_state;
    logic [RowW-1:0] r_clr_row;

    logic            w_issue;
    logic            w_run_store;
    logic [2:0]      w_lo;
    logic [RowW-1:0] w_row;
    logic [RowW-1:0] w_row_next;

    logic            w_we    [NumBanks];
    logic [RowW-1:0] w_baddr [NumBanks];
    logic [7:0]      w_wdata [NumBanks];
    logic [7:0]      w_rdata [NumBanks];

    logic            r_p1_valid;
    logic            r_p1_load;
    logic [1:0]      r_p1_fault;
    logic [2:0]      r_p1_lo;
    logic [3:0]      r_p1_nbytes;
    logic [63:0]     w_asm;
    t_rsp            w_rsp;

    t_rsp              r_oq [OqDepth];
    logic [OqPtrW-1:0] r_oq_wr;
    logic [OqPtrW-1:0] r_oq_rd;
    logic [OqPtrW:0]   r_oq_cnt;
    logic [OqPtrW:0]   n_oq_cnt;
    logic              w_oq_pop;

    // Next state: sweep all rows once after reset
    always_comb begin
        n_state = r_state;
        case (r_state)
            BkClear: begin
                if (r_clr_row == RowW'(Rows - 1)) begin
                    n_state = BkRun;
                end
            end
            BkRun:   n_state = BkRun;
            default: n_state = BkClear;
        endcase
    end

    // State outputs
    always_comb begin
        case (r_state)
            BkClear: o_clearing = 1'b1;
            default: o_clearing = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BkClear;
            r_clr_row <= '0;
        end else begin
            r_state <= n_state;
            if (o_clearing) begin
                r_clr_row <= r_clr_row + RowW'(1);
            end
        end
    end

    // Issue only when the result queue has room for everything in flight
    assign w_issue = !o_clearing && i_cmd_valid
                     && ((r_oq_cnt + (OqPtrW + 1)'(r_p1_valid)) < (OqPtrW + 1)'(OqDepth));
    assign o_cmd_pop = w_issue;

    assign w_run_store = w_issue && i_cmd.is_store && (i_cmd.fault == FaultNone);
    assign w_lo        = i_cmd.addr[2:0];
    assign w_row       = i_cmd.addr[RowW+2:3];
    assign w_row_next  = w_row + RowW'(1);

    // Steer each bank: row, write enable and byte lane
    for (genvar b = 0; b < NumBanks; b++) begin : g_bank
        logic [2:0] w_k;
        logic       w_en;

        assign w_k  = 3'(b) - w_lo;
        assign w_en = {1'b0, w_k} < i_cmd.nbytes;

        always_comb begin
            if (o_clearing) begin
                w_we[b]    = 1'b1;
                w_baddr[b] = r_clr_row;
                w_wdata[b] = 8'd0;
            end else begin
                w_we[b]    = w_run_store && w_en;
                w_baddr[b] = (3'(b) < w_lo) ? w_row_next : w_row;
                w_wdata[b] = i_cmd.data[{w_k, 3'b000} +: 8];
            end
        end

        lebm_ram #(
            .WIDTH(8),
            .DEPTH(Rows)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (w_we[b]),
            .i_addr (w_baddr[b]),
            .i_wdata(w_wdata[b]),
            .o_rdata(w_rdata[b])
        );
    end

    // Track the request whose read data arrives next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else begin
            r_p1_valid <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_p1_load   <= !i_cmd.is_store && (i_cmd.fault == FaultNone);
            r_p1_fault  <= i_cmd.fault;
            r_p1_lo     <= w_lo;
            r_p1_nbytes <= i_cmd.nbytes;
        end
    end

    // Reassemble bytes little-endian, drop lanes beyond the size and all lanes of stores and faults
    always_comb begin
        for (int i = 0; i < NumBanks; i++) begin
            if (r_p1_load && (4'(i) < r_p1_nbytes)) begin
                w_asm[8*i +: 8] = w_rdata[r_p1_lo + 3'(i)];
            end else begin
                w_asm[8*i +: 8] = 8'd0;
            end
        end
    end

    assign w_rsp.read_data = w_asm;
    assign w_rsp.fault     = r_p1_fault;

    // Result queue
    assign o_empty  = (r_oq_cnt == '0);
    assign w_oq_pop = i_pop && !o_empty;
    assign o_rsp    = r_oq[r_oq_rd];

    always_ff @(posedge i_clk) begin
        if (r_p1_valid) begin
            r_oq[r_oq_wr] <= w_rsp;
        end
    end

    always_comb begin
        n_oq_cnt = r_oq_cnt;
        if (r_p1_valid && !w_oq_pop) begin
            n_oq_cnt = r_oq_cnt + (OqPtrW + 1)'(1);
        end else if (!r_p1_valid && w_oq_pop) begin
            n_oq_cnt = r_oq_cnt - (OqPtrW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr  <= '0;
            r_oq_rd  <= '0;
            r_oq_cnt <= '0;
        end else begin
            r_oq_cnt <= n_oq_cnt;
            if (r_p1_valid) begin
                r_oq_wr <= r_oq_wr + OqPtrW'(1);
            end
            if (w_oq_pop) begin
                r_oq_rd <= r_oq_rd + OqPtrW'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* design/little_endian_byte_memory_top.sv */
// A request goes through the front queue, the registered bank read and the result queue.
// Throughput: one request per cycle while the result queue drains, set by the single port of each of eight byte banks.
// Unaligned accesses take one pass: every bank reads or writes its own row at once.
// Reset: synchronous active-low; afterwards the banks are swept to zero, one row per
// cycle, through all ceil(MEM_BYTES/8) rows (8192 by default) with full held high.
`default_nettype none

module little_endian_byte_memory_top
    import lebm_pkg::*;
#(
    parameter int unsigned MEM_BYTES = MemBytesDef
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic push,
    output logic      full,
    input  wire t_req i_req,
    output logic      empty,
    input  wire logic pop,
    output t_rsp      o_rsp
);

    logic w_clearing;
    logic w_cmd_valid;
    logic w_cmd_pop;
    t_cmd w_cmd;

    // Accept and classify requests
    lebm_front #(
        .MEM_BYTES(MEM_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_req      (i_req),
        .o_full     (full),
        .i_clearing (w_clearing),
        .o_cmd_valid(w_cmd_valid),
        .o_cmd      (w_cmd),
        .i_cmd_pop  (w_cmd_pop)
    );

    // Carry out accesses on the byte banks
    lebm_back #(
        .MEM_BYTES(MEM_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(w_cmd_valid),
        .i_cmd      (w_cmd),
        .o_cmd_pop  (w_cmd_pop),
        .o_clearing (w_clearing),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_rsp      (o_rsp)
    );

endmodule

`default_nettype wire

/* design/lebm_checker.sv */
`default_nettype none

module lebm_checker
    import lebm_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic full,
    input wire logic empty,
    input wire logic pop,
    input wire t_rsp o_rsp
);

    // Reset leaves nothing to deliver and blocks requests while clearing
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && full)
        else $error("queues not idle after reset");

    // Only defined fault codes
    a_fault_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_rsp.fault == FaultNone || o_rsp.fault == FaultLoad
                    || o_rsp.fault == FaultStore))
        else $error("undefined fault code");

    // Faulting accesses return no data
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_rsp.fault != FaultNone) |-> (o_rsp.read_data == 64'd0))
        else $error("faulting access returned data");

    // Result holds until popped
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_rsp)))
        else $error("result changed before pop");

endmodule

bind little_endian_byte_memory_top lebm_checker u_lebm_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .o_rsp  (o_rsp)
);

`default_nettype wire
